[hw/rtl/bounded_set_min_max_span_unit_assert.svh]
// Assertion macros shared by the span unit modules.
`ifndef BOUNDED_SET_MIN_MAX_SPAN_UNIT_ASSERT_SVH
`define BOUNDED_SET_MIN_MAX_SPAN_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BSMMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bsmms_pkg.sv]
package bsmms_pkg;

    localparam int MAX_ENTRIES    = 1024;
    localparam int ADDR_W         = $clog2(MAX_ENTRIES);
    localparam int HELD_W         = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W         = 32;
    localparam int GAP_W          = DATA_W + 1;
    localparam int CNT_W          = 11;
    localparam int LIM_W          = (HELD_W > CNT_W) ? HELD_W : CNT_W;
    localparam int MIN_FOR_SPANS  = 2;

    localparam logic [CNT_W-1:0]  CAPACITY_RESET = CNT_W'(1024);
    localparam logic [DATA_W-1:0] SIGN_FLIP      = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        logic scan;
        logic reject;
        logic commit;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic scan_done;
    } sts_t;

endpackage

[hw/rtl/bsmms_ctrl.sv]
module bsmms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bsmms_pkg::sts_t  sts,
    output bsmms_pkg::cmd_t  cmd
);
    import bsmms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_beat;

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.full)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (sts.scan_done)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_RESULT;
                    end
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "bounded_set_min_max_span_unit_assert.svh"

    `BSMMS_ASSERT_NOW(a_load_slot_free, cmd.load, !out_valid_reg || out_ready, "load into busy slot")
    `BSMMS_ASSERT_NEXT(a_load_shows, cmd.load, out_valid_reg, "loaded beat not shown")
    `BSMMS_ASSERT_NEXT(a_beat_starts_scan, in_beat, state_reg == S_SCAN, "beat did not start scan")

endmodule

[hw/rtl/bsmms_dp.sv]
module bsmms_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic [bsmms_pkg::CNT_W-1:0]            cfg_data,
    input  logic signed [bsmms_pkg::DATA_W-1:0]    value,
    input  bsmms_pkg::cmd_t                        cmd,
    output bsmms_pkg::sts_t                        sts,
    output logic                                   status,
    output logic [bsmms_pkg::CNT_W-1:0]            count,
    output logic                                   spans_valid,
    output logic [bsmms_pkg::DATA_W-1:0]           shortest_span,
    output logic [bsmms_pkg::DATA_W-1:0]           longest_span
);
    import bsmms_pkg::*;

    logic [DATA_W-1:0] mem [MAX_ENTRIES];

    logic [CNT_W-1:0]  capacity_reg;
    logic [HELD_W-1:0] held_reg;
    logic [GAP_W-1:0]  min_gap_reg;
    logic [DATA_W-1:0] smallest_reg;
    logic [DATA_W-1:0] largest_reg;
    logic [DATA_W-1:0] value_reg;
    logic [HELD_W-1:0] rd_idx_reg;
    logic              rd_pend_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              gap_pend_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic              reject_reg;

    logic              status_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              spans_valid_reg;
    logic [DATA_W-1:0] shortest_reg;
    logic [DATA_W-1:0] longest_reg;

    logic [LIM_W-1:0]  cap_ext;
    logic [LIM_W-1:0]  limit;
    logic              rd_more;
    logic [GAP_W-1:0]  diff_fwd;
    logic [GAP_W-1:0]  diff_rev;
    logic [DATA_W-1:0] abs_gap;
    logic              held_two;

    // effective limit is capped at the store depth
    assign cap_ext = LIM_W'(capacity_reg);
    assign limit   = (cap_ext > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES) : cap_ext;

    assign sts.full      = (LIM_W'(held_reg) >= limit);
    assign rd_more       = (rd_idx_reg < held_reg);
    assign sts.scan_done = !rd_more && !rd_pend_reg && !gap_pend_reg;

    assign diff_fwd = {1'b0, value_reg} - {1'b0, rd_data_reg};
    assign diff_rev = {1'b0, rd_data_reg} - {1'b0, value_reg};
    assign abs_gap  = diff_fwd[GAP_W-1] ? diff_rev[DATA_W-1:0] : diff_fwd[DATA_W-1:0];

    assign held_two = (held_reg >= HELD_W'(MIN_FOR_SPANS));

    always_ff @(posedge clk)
    begin
        if (cmd.scan && rd_more)
        begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
        if (cmd.commit)
        begin
            mem[held_reg[ADDR_W-1:0]] <= value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            held_reg     <= '0;
            min_gap_reg  <= '1;
            rd_idx_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            gap_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                rd_idx_reg   <= '0;
                rd_pend_reg  <= 1'b0;
                gap_pend_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_pend_reg  <= rd_more;
                gap_pend_reg <= rd_pend_reg;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + HELD_W'(1);
                end
                if (gap_pend_reg && (gap_reg < min_gap_reg))
                begin
                    min_gap_reg <= gap_reg;
                end
            end
            if (cmd.commit)
            begin
                held_reg <= held_reg + HELD_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            value_reg <= $unsigned(value) ^ SIGN_FLIP;
        end
        if (cmd.scan && rd_pend_reg)
        begin
            gap_reg <= {1'b0, abs_gap};
        end
        if (cmd.reject)
        begin
            reject_reg <= 1'b1;
        end
        if (cmd.commit)
        begin
            reject_reg <= 1'b0;
            if (held_reg == '0)
            begin
                smallest_reg <= value_reg;
                largest_reg  <= value_reg;
            end
            else
            begin
                if (value_reg < smallest_reg)
                begin
                    smallest_reg <= value_reg;
                end
                if (value_reg > largest_reg)
                begin
                    largest_reg <= value_reg;
                end
            end
        end
        if (cmd.load)
        begin
            status_reg      <= reject_reg;
            count_reg       <= CNT_W'(held_reg);
            spans_valid_reg <= held_two;
            shortest_reg    <= held_two ? min_gap_reg[DATA_W-1:0] : '0;
            longest_reg     <= held_two ? (largest_reg - smallest_reg) : '0;
        end
    end

    assign status        = status_reg;
    assign count         = count_reg;
    assign spans_valid   = spans_valid_reg;
    assign shortest_span = shortest_reg;
    assign longest_span  = longest_reg;

`include "bounded_set_min_max_span_unit_assert.svh"

    `BSMMS_ASSERT_NOW(a_commit_below_limit, cmd.commit, LIM_W'(held_reg) < limit, "commit past limit")
    `BSMMS_ASSERT_NEXT(a_commit_counts, cmd.commit, held_reg == $past(held_reg) + HELD_W'(1), "held count slip")
    `BSMMS_ASSERT_NEXT(a_gap_monotone, 1'b1, min_gap_reg <= $past(min_gap_reg), "min gap grew")

endmodule

[hw/rtl/bounded_set_min_max_span_unit.sv]
// Bounded set of signed 32-bit numbers reporting shortest and longest spans.
// cfg channel (cfg_valid/cfg_ready, cfg_data): writes the capacity; always ready.
//   Write it only while no add is in flight.
// in channel (in_valid/in_ready, value): one number per beat. in_ready is high
//   whenever no add is being worked on, also while a result waits to be taken.
// out channel (out_valid/out_ready): status, count, spans_valid, shortest_span,
//   longest_span; one result beat per input beat, held until taken.
// Sequence: a rejected add passes from the input beat through the scan state,
//   where it is refused as full, to the result state; an accepted add first has
//   each stored number read once from the single-port store and compared with
//   the new one through a read and compare pipe, and is then committed.
// One add is worked on at a time; the next beat is taken the cycle after the
//   result is loaded.
// A stalled receiver holds the result register; the next add may be taken
//   and worked on, but its result waits until the held beat is taken.
// Reset empties the set, sets capacity to 1024 and clears the shortest-span
//   tracker; the store contents need no clearing.
module bounded_set_min_max_span_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsmms_pkg::CNT_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bsmms_pkg::DATA_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic [bsmms_pkg::CNT_W-1:0]         count,
    output logic                                spans_valid,
    output logic [bsmms_pkg::DATA_W-1:0]        shortest_span,
    output logic [bsmms_pkg::DATA_W-1:0]        longest_span
);
    import bsmms_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bsmms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsmms_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .value         (value),
        .cmd           (cmd),
        .sts           (sts),
        .status        (status),
        .count         (count),
        .spans_valid   (spans_valid),
        .shortest_span (shortest_span),
        .longest_span  (longest_span)
    );

endmodule
